// File: hdl/dom_pkg.sv
// shared types and constants of the drop-oldest message ring
package dom_pkg;

  // fixed field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned DLEN_W      = 6;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned DROP_W      = 32;
  localparam int unsigned SLOTS_CFG_W = 5;
  localparam int unsigned RLIM_W      = 6;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned CFG_IDX_W   = 1;

  // register reset values and counter limit
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RESET = 5'd16;
  localparam logic [RLIM_W-1:0]      RLIM_RESET      = 6'd63;
  localparam logic [DROP_W-1:0]      DROP_MAX        = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_POP    = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS_IN_USE = 1'b0,
    CFG_READ_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LEN    = 5'b00010,
    ST_STREAM = 5'b00100,
    ST_ONE    = 5'b01000,
    ST_MOD    = 5'b10000
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_last;
    logic [DLEN_W-1:0] delivered_length;
    logic [OCC_W-1:0]  occupied_count;
    logic [DROP_W-1:0] dropped_total;
  } out_item_t;

endpackage

// File: hdl/dom_chan_if.sv
// valid/ready channel carrying one payload beat
interface dom_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/dom_store.sv
// message byte memory and message length memory, both with registered reads
module dom_store #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned PTR_W = 4,
  parameter int unsigned POS_W = 6
) (
  input  logic                          clk_i,
  input  logic                          byte_we_i,
  input  logic [PTR_W+POS_W-1:0]        byte_waddr_i,
  input  logic [dom_pkg::BYTE_W-1:0]    byte_wdata_i,
  input  logic [PTR_W+POS_W-1:0]        byte_raddr_i,
  output logic [dom_pkg::BYTE_W-1:0]    byte_rdata_o,
  input  logic                          len_we_i,
  input  logic [PTR_W-1:0]              len_waddr_i,
  input  logic [POS_W-1:0]              len_wdata_i,
  input  logic [PTR_W-1:0]              len_raddr_i,
  output logic [POS_W-1:0]              len_rdata_o
);

  localparam int unsigned BYTE_DEPTH = SLOTS << POS_W;

  logic [dom_pkg::BYTE_W-1:0] byte_mem [BYTE_DEPTH];
  logic [POS_W-1:0]           len_mem  [SLOTS];
  logic [dom_pkg::BYTE_W-1:0] byte_rdata_q;
  logic [POS_W-1:0]           len_rdata_q;

  // byte memory, slot-major with a power-of-two stride
  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      byte_mem[byte_waddr_i] <= byte_wdata_i;
    end
    byte_rdata_q <= byte_mem[byte_raddr_i];
  end

  // length of each committed message
  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    len_rdata_q <= len_mem[len_raddr_i];
  end

  assign byte_rdata_o = byte_rdata_q;
  assign len_rdata_o  = len_rdata_q;

endmodule

// File: hdl/dom_rem.sv
// bit-serial remainder of two dividends by a shared divisor, one bit per cycle
module dom_rem #(
  parameter int unsigned DW = 5,
  parameter int unsigned RW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [DW-1:0] dvd_a_i,
  input  logic [DW-1:0] dvd_b_i,
  output logic          done_o,
  output logic [RW-1:0] rem_a_o,
  output logic [RW-1:0] rem_b_o
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q [2];
  logic [DW-1:0] rem_q [2];
  logic [DW:0]   trial [2];
  logic [DW:0]   rem_nx [2];
  logic          last_step;

  // one restoring step per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], dvd_q[l][DW-1]};
      if (trial[l] >= {1'b0, divisor_i}) begin
        rem_nx[l] = trial[l] - {1'b0, divisor_i};
      end else begin
        rem_nx[l] = trial[l];
      end
    end
  end

  assign last_step = busy_q && (cnt_q == CW'(DW - 1));
  assign done_o    = last_step;
  assign rem_a_o   = RW'(rem_nx[0]);
  assign rem_b_o   = RW'(rem_nx[1]);

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // dividend shift and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q[0] <= dvd_a_i;
      dvd_q[1] <= dvd_b_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        dvd_q[l] <= dvd_q[l] << 1;
        rem_q[l] <= DW'(rem_nx[l]);
      end
    end
  end

endmodule

// File: hdl/drop_oldest_message_ring.sv
// Circular queue of variable-length byte messages that drops the oldest message when full.
// A push beat writes one byte into the byte memory and a close beat commits the message
// length, so while the ring is idle a message streams in at one byte per cycle. A pop
// beat reads the length memory, then reads one byte per cycle, while the output is free,
// from the byte memory into the output register, and no item is taken until the last
// byte is loaded. Empty pop and status beats load their single result from ST_ONE. Writing
// slots_in_use starts a bit-serial remainder pass that recomputes both pointer successors
// and holds off input beats until the pass is done. Bytes are stored at a stride of the
// next power of two above SLOT_BYTES-1 per slot.
module drop_oldest_message_ring #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dom_chan_if.sink                          in_chan,
  dom_chan_if.source                        out_chan,
  input  logic                              cfg_we_i,
  input  logic [dom_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dom_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PTR_W  = $clog2(SLOTS);
  localparam int unsigned WRAP_W = $clog2(SLOTS + 1);
  localparam int unsigned POS_W  = $clog2(SLOT_BYTES);
  localparam int unsigned DLEN_W = dom_pkg::DLEN_W;
  localparam int unsigned CNT_W  = (POS_W < DLEN_W) ? POS_W : DLEN_W;
  localparam int unsigned MW     = (POS_W > DLEN_W) ? POS_W : DLEN_W;
  localparam int unsigned CMP_W  = (WRAP_W > dom_pkg::SLOTS_CFG_W) ? WRAP_W
                                                                  : dom_pkg::SLOTS_CFG_W;

  dom_pkg::state_e                   state_q, state_d;
  logic [dom_pkg::SLOTS_CFG_W-1:0]   slots_cfg_q, slots_cfg_d;
  logic [dom_pkg::RLIM_W-1:0]        rlim_q, rlim_d;
  logic [PTR_W-1:0]                  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]                  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]                  wr_nxt_q, wr_nxt_d;
  logic [PTR_W-1:0]                  rd_nxt_q, rd_nxt_d;
  logic [WRAP_W-1:0]                 occ_q, occ_d;
  logic [dom_pkg::DROP_W-1:0]        drop_q, drop_d;
  logic [POS_W-1:0]                  fill_q, fill_d;
  logic                              open_q, open_d;
  logic [PTR_W-1:0]                  pop_slot_q, pop_slot_d;
  logic [CNT_W-1:0]                  n_q, n_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  dom_pkg::kind_e                    one_kind_q, one_kind_d;
  logic                              out_valid_q, out_valid_d;
  dom_pkg::out_item_t                out_q, out_d;

  dom_pkg::in_item_t                 in_item;
  logic                              in_acc;
  logic                              out_free;
  logic                              out_load;
  logic [WRAP_W-1:0]                 wrap_cnt;
  logic [WRAP_W-1:0]                 wr_nxt_inc, rd_nxt_inc;
  logic [PTR_W-1:0]                  wr_nxt_adv, rd_nxt_adv;
  logic                              do_drop;
  logic [POS_W-1:0]                  fill_idx;
  logic [WRAP_W-1:0]                 occ_adj;
  logic [CNT_W-1:0]                  cnt_inc;
  logic [CNT_W-1:0]                  byte_rd_pos;
  logic [CNT_W-1:0]                  n_calc;
  logic [MW-1:0]                     len_x, lim_x;

  logic                              byte_we;
  logic [dom_pkg::BYTE_W-1:0]        byte_rdata;
  logic                              len_we;
  logic [POS_W-1:0]                  len_rdata;

  logic                              rem_start;
  logic                              rem_done;
  logic [PTR_W-1:0]                  rem_wr, rem_rd;

  assign in_item          = in_chan.payload;
  assign in_chan.ready    = (state_q == dom_pkg::ST_IDLE);
  assign in_acc           = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_valid_q;
  assign out_chan.payload = out_q;
  assign out_free         = !out_valid_q || out_chan.ready;

  // slot count the pointers wrap over, clamped to 1..SLOTS
  always_comb begin
    if (slots_cfg_q == '0) begin
      wrap_cnt = WRAP_W'(1);
    end else if (CMP_W'(slots_cfg_q) > CMP_W'(SLOTS)) begin
      wrap_cnt = WRAP_W'(SLOTS);
    end else begin
      wrap_cnt = WRAP_W'(slots_cfg_q);
    end
  end

  // pointer successors, already reduced below the wrap count
  assign wr_nxt_inc = WRAP_W'(wr_nxt_q) + WRAP_W'(1);
  assign rd_nxt_inc = WRAP_W'(rd_nxt_q) + WRAP_W'(1);
  assign wr_nxt_adv = (wr_nxt_inc == wrap_cnt) ? '0 : PTR_W'(wr_nxt_inc);
  assign rd_nxt_adv = (rd_nxt_inc == wrap_cnt) ? '0 : PTR_W'(rd_nxt_inc);

  // message start bookkeeping
  assign do_drop  = !open_q && (occ_q >= wrap_cnt);
  assign fill_idx = open_q ? fill_q : '0;
  assign occ_adj  = do_drop ? (occ_q - WRAP_W'(1)) : occ_q;

  // truncated pop length
  assign len_x  = MW'(len_rdata);
  assign lim_x  = MW'(rlim_q);
  assign n_calc = (len_x > lim_x) ? CNT_W'(lim_x) : CNT_W'(len_x);

  assign cnt_inc = cnt_q + CNT_W'(1);

  // main control
  always_comb begin
    state_d     = state_q;
    slots_cfg_d = slots_cfg_q;
    rlim_d      = rlim_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    wr_nxt_d    = wr_nxt_q;
    rd_nxt_d    = rd_nxt_q;
    occ_d       = occ_q;
    drop_d      = drop_q;
    fill_d      = fill_q;
    open_d      = open_q;
    pop_slot_d  = pop_slot_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    one_kind_d  = one_kind_q;
    out_load    = 1'b0;
    out_d       = out_q;
    byte_we     = 1'b0;
    len_we      = 1'b0;
    byte_rd_pos = cnt_q;
    rem_start   = 1'b0;

    unique case (state_q)
      dom_pkg::ST_IDLE: begin
        if (in_acc) begin
          // a message start on a full queue drops the oldest message
          if (((in_item.command == dom_pkg::CMD_PUSH) ||
               (in_item.command == dom_pkg::CMD_CLOSE)) && do_drop) begin
            rd_ptr_d = rd_nxt_q;
            rd_nxt_d = rd_nxt_adv;
            if (drop_q != dom_pkg::DROP_MAX) begin
              drop_d = drop_q + dom_pkg::DROP_W'(1);
            end
          end
          case (in_item.command)
            dom_pkg::CMD_PUSH: begin
              occ_d  = occ_adj;
              open_d = 1'b1;
              fill_d = fill_idx;
              if (fill_idx < POS_W'(SLOT_BYTES - 1)) begin
                byte_we = 1'b1;
                fill_d  = fill_idx + POS_W'(1);
              end
            end
            dom_pkg::CMD_CLOSE: begin
              len_we   = 1'b1;
              wr_ptr_d = wr_nxt_q;
              wr_nxt_d = wr_nxt_adv;
              occ_d    = (occ_adj < WRAP_W'(SLOTS)) ? (occ_adj + WRAP_W'(1)) : occ_adj;
              open_d   = 1'b0;
              fill_d   = '0;
            end
            dom_pkg::CMD_POP: begin
              if (occ_q == '0) begin
                one_kind_d = dom_pkg::KIND_EMPTY;
                state_d    = dom_pkg::ST_ONE;
              end else begin
                pop_slot_d = rd_ptr_q;
                rd_ptr_d   = rd_nxt_q;
                rd_nxt_d   = rd_nxt_adv;
                occ_d      = occ_q - WRAP_W'(1);
                state_d    = dom_pkg::ST_LEN;
              end
            end
            dom_pkg::CMD_STATUS: begin
              one_kind_d = dom_pkg::KIND_STATUS;
              state_d    = dom_pkg::ST_ONE;
            end
            default: ;
          endcase
        end
      end
      dom_pkg::ST_LEN: begin
        // length is back, start the byte reads at offset zero
        n_d         = n_calc;
        cnt_d       = '0;
        byte_rd_pos = '0;
        if (n_calc == '0) begin
          one_kind_d = dom_pkg::KIND_ZERO;
          state_d    = dom_pkg::ST_ONE;
        end else begin
          state_d = dom_pkg::ST_STREAM;
        end
      end
      dom_pkg::ST_STREAM: begin
        // read data always belongs to cnt_q; a stall re-reads the same byte
        if (out_free) begin
          out_load                 = 1'b1;
          out_d.result_kind        = dom_pkg::KIND_BYTE;
          out_d.out_byte           = byte_rdata;
          out_d.byte_last          = (cnt_inc == n_q);
          out_d.delivered_length   = DLEN_W'(n_q);
          out_d.occupied_count     = '0;
          out_d.dropped_total      = '0;
          byte_rd_pos              = cnt_inc;
          cnt_d                    = cnt_inc;
          if (cnt_inc == n_q) begin
            state_d = dom_pkg::ST_IDLE;
          end
        end
      end
      dom_pkg::ST_ONE: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_d.result_kind      = one_kind_q;
          out_d.out_byte         = '0;
          out_d.byte_last        = 1'b1;
          out_d.delivered_length = '0;
          if (one_kind_q == dom_pkg::KIND_STATUS) begin
            out_d.occupied_count = dom_pkg::OCC_W'(occ_q);
            out_d.dropped_total  = drop_q;
          end else begin
            out_d.occupied_count = '0;
            out_d.dropped_total  = '0;
          end
          state_d = dom_pkg::ST_IDLE;
        end
      end
      dom_pkg::ST_MOD: begin
        if (rem_done) begin
          wr_nxt_d = rem_wr;
          rd_nxt_d = rem_rd;
          state_d  = dom_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dom_pkg::ST_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dom_pkg::CFG_SLOTS_IN_USE: begin
          slots_cfg_d = cfg_wdata_i[dom_pkg::SLOTS_CFG_W-1:0];
          rem_start   = 1'b1;
          state_d     = dom_pkg::ST_MOD;
        end
        dom_pkg::CFG_READ_LIMIT: begin
          rlim_d = cfg_wdata_i[dom_pkg::RLIM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dom_pkg::ST_IDLE;
      slots_cfg_q <= dom_pkg::SLOTS_CFG_RESET;
      rlim_q      <= dom_pkg::RLIM_RESET;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      wr_nxt_q    <= PTR_W'(1);
      rd_nxt_q    <= PTR_W'(1);
      occ_q       <= '0;
      drop_q      <= '0;
      fill_q      <= '0;
      open_q      <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slots_cfg_q <= slots_cfg_d;
      rlim_q      <= rlim_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_nxt_q    <= wr_nxt_d;
      rd_nxt_q    <= rd_nxt_d;
      occ_q       <= occ_d;
      drop_q      <= drop_d;
      fill_q      <= fill_d;
      open_q      <= open_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pop_slot_q <= pop_slot_d;
    one_kind_q <= one_kind_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // message storage
  dom_store #(
    .SLOTS (SLOTS),
    .PTR_W (PTR_W),
    .POS_W (POS_W)
  ) u_store (
    .clk_i        (clk_i),
    .byte_we_i    (byte_we),
    .byte_waddr_i ({wr_ptr_q, fill_idx}),
    .byte_wdata_i (in_item.data_byte),
    .byte_raddr_i ({pop_slot_q, POS_W'(byte_rd_pos)}),
    .byte_rdata_o (byte_rdata),
    .len_we_i     (len_we),
    .len_waddr_i  (wr_ptr_q),
    .len_wdata_i  (fill_idx),
    .len_raddr_i  (rd_ptr_q),
    .len_rdata_o  (len_rdata)
  );

  // pointer rewrap after a slot count change
  dom_rem #(
    .DW (WRAP_W),
    .RW (PTR_W)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .divisor_i (wrap_cnt),
    .dvd_a_i   (WRAP_W'(wr_ptr_q) + WRAP_W'(1)),
    .dvd_b_i   (WRAP_W'(rd_ptr_q) + WRAP_W'(1)),
    .done_o    (rem_done),
    .rem_a_o   (rem_wr),
    .rem_b_o   (rem_rd)
  );

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= WRAP_W'(SLOTS))
    else $error("occupancy above slot count");

  a_pop_reads_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item.command == dom_pkg::CMD_POP) && (occ_q != '0) && !cfg_we_i
    |=> (state_q == dom_pkg::ST_LEN))
    else $error("pop of a held message did not read its length");

  a_stream_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dom_pkg::ST_STREAM) |-> (cnt_q < n_q))
    else $error("stream index past message length");

  a_succ_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dom_pkg::ST_IDLE)
    |-> (WRAP_W'(wr_nxt_q) < wrap_cnt) && (WRAP_W'(rd_nxt_q) < wrap_cnt))
    else $error("pointer successor not below wrap count");
`endif

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench of the drop-oldest message ring
module tb_top;
  import dom_pkg::*;

  localparam int unsigned SLOT_COUNT  = 16;
  localparam int unsigned SLOT_SPAN   = 64;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 22;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned RUN_LIMIT   = 3_000_000;
  localparam int unsigned DIR_ROWS    = 20;

  // how a directed row is applied
  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_CHECKED = 2'd1,
    ROW_CONFIG  = 2'd2
  } row_e;

  typedef struct packed {
    row_e        op;
    cmd_e        cmd;
    logic [7:0]  data;
    logic [6:0]  reps;
    kind_e       kind;
    logic [4:0]  occ;
    logic [31:0] drop;
    logic [5:0]  slots;
    logic [5:0]  rlim;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dom_chan_if #(.T(in_item_t))  cmd_ch ();
  dom_chan_if #(.T(out_item_t)) res_ch ();

  always #2 clk_i = ~clk_i;

  drop_oldest_message_ring #(
    .SLOTS      (SLOT_COUNT),
    .SLOT_BYTES (SLOT_SPAN)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (cmd_ch),
    .out_chan    (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // directed stimulus: typed results where they are obvious, the rest predicted
  step_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CHECKED, CMD_POP,    8'h00, 7'd1,  KIND_EMPTY,  5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CHECKED, CMD_STATUS, 8'hFF, 7'd1,  KIND_STATUS, 5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_CLOSE,  8'hA5, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CHECKED, CMD_POP,    8'h3C, 7'd1,  KIND_ZERO,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_PUSH,   8'h00, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_PUSH,   8'hFF, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_PUSH,   8'h5A, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_CLOSE,  8'h00, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_POP,    8'hC3, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_PUSH,   8'h80, 7'd66, KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_CLOSE,  8'h00, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_POP,    8'h00, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CONFIG,  CMD_STATUS, 8'h00, 7'd0,  KIND_BYTE,   5'd0, 32'd0, 6'd2, 6'd63},
    '{ROW_PREDICT, CMD_CLOSE,  8'h00, 7'd3,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CHECKED, CMD_STATUS, 8'h00, 7'd1,  KIND_STATUS, 5'd2, 32'd1, 6'd0, 6'd0},
    '{ROW_CONFIG,  CMD_STATUS, 8'h00, 7'd0,  KIND_BYTE,   5'd0, 32'd0, 6'd2, 6'd0},
    '{ROW_PREDICT, CMD_PUSH,   8'h33, 7'd2,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_PREDICT, CMD_CLOSE,  8'h00, 7'd1,  KIND_BYTE,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CHECKED, CMD_POP,    8'h00, 7'd1,  KIND_ZERO,   5'd0, 32'd0, 6'd0, 6'd0},
    '{ROW_CHECKED, CMD_STATUS, 8'h00, 7'd1,  KIND_STATUS, 5'd1, 32'd2, 6'd0, 6'd0}
  };

  // register settings of the random phases, extremes included
  logic [5:0] phase_slots [PHASES] = '{6'd16, 6'd1, 6'd4, 6'd0, 6'd31, 6'd33, 6'd8, 6'd3, 6'd16};
  logic [5:0] phase_rlim  [PHASES] = '{6'd63, 6'd0, 6'd5, 6'd63, 6'd20, 6'd1, 6'd63, 6'd12, 6'd63};

  // ring shadow state
  logic [7:0]  msg_mem [SLOT_COUNT][SLOT_SPAN];
  logic [5:0]  len_mem [SLOT_COUNT];
  bit          len_valid [SLOT_COUNT];
  int unsigned wr_slot;
  int unsigned rd_slot;
  int unsigned held;
  logic [31:0] drops;
  int unsigned fill;
  bit          msg_open;
  logic [4:0]  cfg_slots;
  logic [5:0]  cfg_rlim;

  out_item_t beat_out [$];
  out_item_t pending_results [$];
  int        bad_beats = 0;
  bit        calm = 1'b0;

  function automatic out_item_t mk_res(kind_e k, logic [7:0] b, logic l, logic [5:0] n,
                                       logic [4:0] occ, logic [31:0] drp);
    out_item_t r;
    r.result_kind      = k;
    r.out_byte         = b;
    r.byte_last        = l;
    r.delivered_length = n;
    r.occupied_count   = occ;
    r.dropped_total    = drp;
    return r;
  endfunction

  function automatic void ring_reset();
    foreach (len_valid[i]) len_valid[i] = 1'b0;
    wr_slot   = 0;
    rd_slot   = 0;
    held      = 0;
    drops     = '0;
    fill      = 0;
    msg_open  = 1'b0;
    cfg_slots = SLOTS_CFG_RESET;
    cfg_rlim  = RLIM_RESET;
  endfunction

  // slot count the pointers wrap at, clamped to the built size
  function automatic int unsigned ring_wrap();
    int unsigned c;
    c = cfg_slots;
    if (c < 1) c = 1;
    if (c > SLOT_COUNT) c = SLOT_COUNT;
    return c;
  endfunction

  function automatic int unsigned ring_next(int unsigned s);
    return (s + 1) % ring_wrap();
  endfunction

  // a new message drops the oldest one when the ring is full
  function automatic void ring_start();
    if (held >= ring_wrap()) begin
      rd_slot = ring_next(rd_slot);
      if (held > 0) held--;
      if (drops != DROP_MAX) drops++;
    end
    msg_open = 1'b1;
    fill     = 0;
  endfunction

  // results caused by one command beat, left in beat_out
  function automatic void ring_apply(in_item_t it);
    int unsigned n;
    int unsigned s;
    beat_out.delete();
    case (it.command)
      CMD_PUSH: begin
        if (!msg_open) ring_start();
        if (fill < SLOT_SPAN - 1) begin
          msg_mem[wr_slot][fill] = it.data_byte;
          fill++;
        end
      end
      CMD_CLOSE: begin
        if (!msg_open) ring_start();
        len_mem[wr_slot]   = 6'(fill);
        len_valid[wr_slot] = 1'b1;
        wr_slot = ring_next(wr_slot);
        if (held < SLOT_COUNT) held++;
        msg_open = 1'b0;
        fill     = 0;
      end
      CMD_POP: begin
        if (held == 0) begin
          beat_out.push_back(mk_res(KIND_EMPTY, 8'h00, 1'b1, 6'd0, 5'd0, 32'd0));
        end else begin
          s = rd_slot;
          n = len_mem[s];
          if (n > cfg_rlim) n = cfg_rlim;
          rd_slot = ring_next(rd_slot);
          held--;
          if (n == 0) begin
            beat_out.push_back(mk_res(KIND_ZERO, 8'h00, 1'b1, 6'd0, 5'd0, 32'd0));
          end else begin
            for (int i = 0; i < n; i++) begin
              beat_out.push_back(mk_res(KIND_BYTE, msg_mem[s][i], 1'(i + 1 == n), 6'(n),
                                        5'd0, 32'd0));
            end
          end
        end
      end
      default: begin
        beat_out.push_back(mk_res(KIND_STATUS, 8'h00, 1'b1, 6'd0, 5'(held), drops));
      end
    endcase
  endfunction

  // a pop must never read a length that was never written
  function automatic bit pop_safe();
    return (held == 0) || len_valid[rd_slot];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic int unsigned pick_stall();
    if ($urandom_range(9) == 0) return $urandom_range(8, 24);
    return $urandom_range(1, 3);
  endfunction

  // offer one command beat and wait for it to be taken
  task automatic send_beat(cmd_e c, logic [7:0] d);
    in_item_t    it;
    int unsigned gap;
    it.command   = c;
    it.data_byte = d;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= it;
    do @(posedge clk_i); while (!cmd_ch.ready);
    ring_apply(it);
  endtask

  task automatic send_predicted(cmd_e c, logic [7:0] d);
    send_beat(c, d);
    foreach (beat_out[i]) pending_results.push_back(beat_out[i]);
  endtask

  // stop sending and let every pending result drain
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write read limit, then slot count; only called while idle
  task automatic set_config(logic [5:0] slots, logic [5:0] rlim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_READ_LIMIT;
    cfg_wdata_i <= rlim;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SLOTS_IN_USE;
    cfg_wdata_i <= slots;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_rlim  = rlim;
    cfg_slots = slots[4:0];
  endtask

  // result sink with random stalls
  initial begin : sink_proc
    int unsigned run;
    res_ch.ready <= 1'b0;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run > 0) begin
        run--;
      end else if (calm || $urandom_range(1) == 0) begin
        res_ch.ready <= 1'b1;
        run = $urandom_range(1, 16);
      end else begin
        res_ch.ready <= 1'b0;
        run = pick_stall();
      end
    end
  end

  // compare each accepted result beat with the oldest pending one
  always @(posedge clk_i) begin : check_proc
    out_item_t want;
    out_item_t got;
    if (rst_ni === 1'b1 && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (pending_results.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("tb_top: unexpected result beat, kind %0d byte %02h",
                   got.result_kind, got.out_byte);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
            got.byte_last !== want.byte_last ||
            got.delivered_length !== want.delivered_length ||
            got.occupied_count !== want.occupied_count ||
            got.dropped_total !== want.dropped_total) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("tb_top: mismatch, exp kind %0d byte %02h last %0b len %0d occ %0d drop %0d",
                     want.result_kind, want.out_byte, want.byte_last,
                     want.delivered_length, want.occupied_count, want.dropped_total);
            $display("tb_top: mismatch, act kind %0d byte %02h last %0b len %0d occ %0d drop %0d",
                     got.result_kind, got.out_byte, got.byte_last,
                     got.delivered_length, got.occupied_count, got.dropped_total);
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : main_proc
    int unsigned items;
    int unsigned len;
    int unsigned pick;
    bit          paused;
    rst_ni         <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_SLOTS_IN_USE;
    cfg_wdata_i    <= '0;
    paused = 1'b0;
    ring_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[r]) begin
      case (dir_rows[r].op)
        ROW_CONFIG: begin
          settle();
          set_config(dir_rows[r].slots, dir_rows[r].rlim);
        end
        ROW_CHECKED: begin
          send_beat(dir_rows[r].cmd, dir_rows[r].data);
          pending_results.push_back(mk_res(dir_rows[r].kind, 8'h00, 1'b1, 6'd0,
                                           dir_rows[r].occ, dir_rows[r].drop));
        end
        default: begin
          for (int k = 0; k < dir_rows[r].reps; k++)
            send_predicted(dir_rows[r].cmd, 8'(dir_rows[r].data + k));
        end
      endcase
    end

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_config(phase_slots[p], phase_rlim[p]);
      calm  = (p == 2) || (p == 6);
      items = 0;
      while (items < PHASE_ITEMS) begin
        // hold off once until the ring has answered everything
        if (p == 4 && items >= 10 && !paused) begin
          settle();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          // well-formed message: bytes then close
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
          repeat (len) send_predicted(CMD_PUSH, 8'($urandom_range(255)));
          send_predicted(CMD_CLOSE, 8'($urandom_range(255)));
          items += len + 1;
        end else if (pick < 75) begin
          send_predicted(pop_safe() ? CMD_POP : CMD_STATUS, 8'($urandom_range(255)));
          items++;
        end else if (pick < 85) begin
          send_predicted(CMD_STATUS, 8'($urandom_range(255)));
          items++;
        end else if (pick < 93) begin
          send_predicted(CMD_PUSH, 8'($urandom_range(255)));
          items++;
        end else begin
          send_predicted(CMD_CLOSE, 8'($urandom_range(255)));
          items++;
        end
      end
    end

    calm = 1'b0;
    settle();
    if (bad_beats == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
